FILE: src/assert_macros.svh
// assertion helpers for the scan formatter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define SSF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/ssf_pkg.sv
package ssf_pkg;

    // digit positions per display in the code store
    localparam int STORE_DIGITS = 4;

    // request kinds
    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_SHOW  = 2'd1;
    localparam logic [1:0] OP_RAW   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // register indexes
    localparam logic [2:0] REG_DIGITS_FIRST  = 3'd0;
    localparam logic [2:0] REG_DIGITS_SECOND = 3'd1;
    localparam logic [2:0] REG_BLANK_CODE    = 3'd2;
    localparam logic [2:0] REG_MINUS_CODE    = 3'd3;
    localparam logic [2:0] REG_ERROR_CODE    = 3'd4;
    localparam logic [2:0] REG_DOT_MASK      = 3'd5;

    // reciprocal of ten, exact for every 16-bit magnitude
    localparam logic [15:0] RECIP_TEN = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef logic [3:0] bcd_digit_t;

    typedef struct packed {
        logic                               busy;
        logic                               done;
        logic                               overflow;
        logic [STORE_DIGITS-1:0][3:0]       digit;
    } split_status_t;

    function automatic logic [7:0] seg_code(input bcd_digit_t d);
        logic [7:0] c;
        case (d)
            4'd0:    c = 8'd3;
            4'd1:    c = 8'd159;
            4'd2:    c = 8'd37;
            4'd3:    c = 8'd13;
            4'd4:    c = 8'd153;
            4'd5:    c = 8'd73;
            4'd6:    c = 8'd65;
            4'd7:    c = 8'd31;
            4'd8:    c = 8'd1;
            4'd9:    c = 8'd9;
            default: c = 8'd3;
        endcase
        return c;
    endfunction

endpackage

FILE: src/ssf_ram.sv
module ssf_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/ssf_bcd_split.sv
// splits a magnitude into decimal digits, one digit per cycle
module ssf_bcd_split (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [15:0]           magnitude,
    input  logic [2:0]            num_digits,
    output ssf_pkg::split_status_t status
);

    logic [15:0] mag_reg, mag_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  len_reg, len_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [ssf_pkg::STORE_DIGITS-1:0][3:0] digit_reg, digit_next;

    logic [31:0] product;
    logic [15:0] quotient;
    logic [15:0] remainder;

    always_comb begin
        product   = mag_reg * ssf_pkg::RECIP_TEN;
        quotient  = 16'(product >> ssf_pkg::RECIP_SHIFT);
        remainder = mag_reg - ((quotient << 3) + (quotient << 1));
    end

    always_comb begin
        mag_next   = mag_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        digit_next = digit_reg;
        if (start) begin
            mag_next  = magnitude;
            cnt_next  = 3'd0;
            len_next  = num_digits;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            digit_next[cnt_reg[1:0]] = remainder[3:0];
            mag_next = quotient;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_next == len_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mag_reg   <= mag_next;
        len_reg   <= len_next;
        digit_reg <= digit_next;
    end

    always_comb begin
        status.busy     = busy_reg;
        status.done     = done_reg;
        status.overflow = (mag_reg != 16'd0);
        status.digit    = digit_reg;
    end

endmodule

FILE: src/seven_segment_scan_formatter.sv
// multiplexed seven-segment driver for up to two displays of up to four digits
//
// requests arrive on the s_ stream: tuser carries the operation (scan tick,
// show number, write raw codes, clear), tdata the number, point flag, display
// and raw codes. every request gives one result on the m_ stream: the code of
// the lit digit and the one-hot cathode.
// digit codes live in a small ram, one row of digit codes per display. each
// request runs a sequence: execute, optional decimal split, row write (none
// for a scan tick), row read, output load.
// a request is taken only in the idle state, so the block finishes one request
// before it accepts the next; a number write waits on the split unit, which
// produces one decimal digit per cycle for each fitted digit of its display.
// the result is loaded into the output register from the response state; a
// new request can be taken while it waits there, but a stalled receiver holds
// the next result back in the output stage.
// reset clears the cathode (no digit lit), the output valid and the row
// valid bits, so every stored code reads as zero until a row is written, and
// loads the register defaults. the apb port is always ready.
module seven_segment_scan_formatter #(
    parameter int MAX_DIGITS   = 4,
    parameter int NUM_DISPLAYS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // value[15:0], dot_flag[16], display[17], raw_units[25:18],
    // raw_tens[33:26], raw_hundreds[41:34], raw_thousands[49:42], zero pad
    input  logic [55:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // segment_code[7:0], digit_select[15:8]
    output logic [15:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROW_W  = MAX_DIGITS * 8;
    localparam int ROW_AW = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SPLIT = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    // configuration registers
    logic [2:0] digits_first_reg, digits_second_reg;
    logic [7:0] blank_code_reg, minus_code_reg, error_code_reg, dot_mask_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_first_reg  <= 3'd4;
            digits_second_reg <= 3'd4;
            blank_code_reg    <= 8'd255;
            minus_code_reg    <= 8'd253;
            error_code_reg    <= 8'd97;
            dot_mask_reg      <= 8'd254;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                ssf_pkg::REG_DIGITS_FIRST:  digits_first_reg  <= pwdata[2:0];
                ssf_pkg::REG_DIGITS_SECOND: digits_second_reg <= pwdata[2:0];
                ssf_pkg::REG_BLANK_CODE:    blank_code_reg    <= pwdata[7:0];
                ssf_pkg::REG_MINUS_CODE:    minus_code_reg    <= pwdata[7:0];
                ssf_pkg::REG_ERROR_CODE:    error_code_reg    <= pwdata[7:0];
                ssf_pkg::REG_DOT_MASK:      dot_mask_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            ssf_pkg::REG_DIGITS_FIRST:  prdata = {29'd0, digits_first_reg};
            ssf_pkg::REG_DIGITS_SECOND: prdata = {29'd0, digits_second_reg};
            ssf_pkg::REG_BLANK_CODE:    prdata = {24'd0, blank_code_reg};
            ssf_pkg::REG_MINUS_CODE:    prdata = {24'd0, minus_code_reg};
            ssf_pkg::REG_ERROR_CODE:    prdata = {24'd0, error_code_reg};
            ssf_pkg::REG_DOT_MASK:      prdata = {24'd0, dot_mask_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // fitted digit counts, clamped
    logic [2:0] fit_first, fit_second;

    always_comb begin
        if (digits_first_reg == 3'd0) begin
            fit_first = 3'd1;
        end else if (digits_first_reg > 3'(MAX_DIGITS)) begin
            fit_first = 3'(MAX_DIGITS);
        end else begin
            fit_first = digits_first_reg;
        end
        if (NUM_DISPLAYS < 2) begin
            fit_second = 3'd0;
        end else if (digits_second_reg > 3'(MAX_DIGITS)) begin
            fit_second = 3'(MAX_DIGITS);
        end else begin
            fit_second = digits_second_reg;
        end
    end

    // latched request
    logic [2:0]  state_reg, state_next;
    logic [1:0]  op_reg;
    logic [15:0] value_reg;
    logic        dot_reg;
    logic        disp_reg;
    logic [31:0] raw_reg;
    logic        req_acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign req_acc  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (req_acc) begin
            op_reg    <= s_tuser;
            value_reg <= s_tdata[15:0];
            dot_reg   <= s_tdata[16];
            disp_reg  <= s_tdata[17];
            raw_reg   <= s_tdata[49:18];
        end
    end

    // cathode decode
    logic [7:0] cathode_reg, cathode_next;
    logic       cat_onehot;
    logic [2:0] cat_bit;
    logic       slot_ok;
    logic [7:0] scan_next;

    always_comb begin
        cat_onehot = (cathode_reg != 8'd0) && ((cathode_reg & (cathode_reg - 8'd1)) == 8'd0);
        cat_bit = 3'd0;
        for (int b = 0; b < 8; b++) begin
            if (cathode_reg[b]) begin
                cat_bit = 3'(b);
            end
        end
        if (!cat_bit[2]) begin
            slot_ok = cat_onehot && ({1'b0, cat_bit[1:0]} < fit_first);
        end else begin
            slot_ok = cat_onehot && ({1'b0, cat_bit[1:0]} < fit_second);
        end

        // one-hot, so the next digit up is a left shift
        if (!slot_ok) begin
            scan_next = 8'd1;
        end else if (!cat_bit[2]) begin
            if ({1'b0, cat_bit[1:0]} + 3'd1 < fit_first) begin
                scan_next = cathode_reg << 1;
            end else if (fit_second != 3'd0) begin
                scan_next = 8'd16;
            end else begin
                scan_next = 8'd1;
            end
        end else begin
            if ({1'b0, cat_bit[1:0]} + 3'd1 < fit_second) begin
                scan_next = cathode_reg << 1;
            end else begin
                scan_next = 8'd1;
            end
        end
    end

    // number conversion
    logic [2:0]             disp_digits;
    logic                   neg;
    logic [15:0]            magnitude;
    logic                   split_start;
    ssf_pkg::split_status_t split;

    always_comb begin
        disp_digits = disp_reg ? fit_second : fit_first;
        neg         = value_reg[15];
        magnitude   = neg ? (~value_reg + 16'd1) : value_reg;
    end

    ssf_bcd_split u_split (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (split_start),
        .magnitude  (magnitude),
        .num_digits (disp_digits),
        .status     (split)
    );

    logic [ssf_pkg::STORE_DIGITS-1:0][7:0] fmt_code;
    logic [ssf_pkg::STORE_DIGITS:0]        fmt_blank;
    logic [1:0]                            top_idx;
    logic                                  minus_done;
    logic [ROW_W-1:0]                      fmt_row;

    always_comb begin
        top_idx    = 2'(disp_digits - 3'd1);
        minus_done = 1'b0;
        fmt_blank[ssf_pkg::STORE_DIGITS] = 1'b1;
        for (int i = 0; i < ssf_pkg::STORE_DIGITS; i++) begin
            if (3'(i) < disp_digits) begin
                fmt_code[i]  = ssf_pkg::seg_code(split.digit[i]);
                fmt_blank[i] = 1'b0;
            end else begin
                fmt_code[i]  = blank_code_reg;
                fmt_blank[i] = 1'b1;
            end
        end
        // leading-zero blanking, units digit always lit
        for (int i = ssf_pkg::STORE_DIGITS - 1; i > 0; i--) begin
            if ((3'(i) < disp_digits) && fmt_blank[i+1] && (split.digit[i] == 4'd0)) begin
                fmt_code[i]  = blank_code_reg;
                fmt_blank[i] = 1'b1;
            end
        end
        // overflow, or no room left for the sign
        if (split.overflow || (neg && !fmt_blank[top_idx])) begin
            fmt_code[top_idx]  = error_code_reg;
            fmt_blank[top_idx] = 1'b0;
        end
        // minus just above the leading digit
        if (neg) begin
            for (int i = ssf_pkg::STORE_DIGITS - 1; i > 0; i--) begin
                if (!minus_done && (3'(i) < disp_digits) && fmt_blank[i]
                    && !fmt_blank[i-1]) begin
                    fmt_code[i] = minus_code_reg;
                    minus_done  = 1'b1;
                end
            end
        end
        if (dot_reg) begin
            fmt_code[0] = fmt_code[0] & dot_mask_reg;
        end
        for (int p = 0; p < MAX_DIGITS; p++) begin
            fmt_row[p*8 +: 8] = fmt_code[p];
        end
    end

    // code store, one row per display
    logic                    ram_we;
    logic [ROW_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [ROW_W-1:0]        ram_rdata;
    logic [NUM_DISPLAYS-1:0] row_valid_reg, row_valid_next;
    logic                    disp_fitted;

    assign disp_fitted = (int'(disp_reg) < NUM_DISPLAYS);

    ssf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_DISPLAYS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ROW_AW'(disp_reg)),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ROW_AW'(cat_bit[2])),
        .rd_data (ram_rdata)
    );

    // read-side flags captured with the row read
    logic       rd_slot_ok_reg;
    logic       rd_row_ok_reg;
    logic [1:0] rd_pos_reg;
    logic [31:0] rd_row32;
    logic [7:0] seg_out;

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            rd_slot_ok_reg <= slot_ok;
            rd_row_ok_reg  <= row_valid_reg[ROW_AW'(cat_bit[2])];
            rd_pos_reg     <= cat_bit[1:0];
        end
    end

    always_comb begin
        rd_row32 = 32'(ram_rdata);
        if (!rd_slot_ok_reg) begin
            seg_out = blank_code_reg;
        end else if (!rd_row_ok_reg) begin
            seg_out = 8'd0;
        end else begin
            seg_out = rd_row32[rd_pos_reg*8 +: 8];
        end
    end

    // output stage
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg;
    logic        out_load;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cathode_next   = cathode_reg;
        row_valid_next = row_valid_reg;
        split_start    = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = fmt_row;
        ram_re         = 1'b0;
        out_load       = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (req_acc) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_READ;
                case (op_reg)
                    ssf_pkg::OP_SCAN: begin
                        cathode_next = scan_next;
                    end
                    ssf_pkg::OP_SHOW: begin
                        if (disp_digits != 3'd0) begin
                            split_start = 1'b1;
                            state_next  = ST_SPLIT;
                        end
                    end
                    ssf_pkg::OP_RAW: begin
                        ram_we    = disp_fitted;
                        ram_wdata = raw_reg[ROW_W-1:0];
                    end
                    default: begin
                        ram_we    = disp_fitted;
                        ram_wdata = {MAX_DIGITS{blank_code_reg}};
                    end
                endcase
            end
            ST_SPLIT: begin
                if (split.done) begin
                    ram_we     = disp_fitted;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (ram_we) begin
            row_valid_next[ROW_AW'(disp_reg)] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cathode_reg   <= 8'd0;
            row_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cathode_reg   <= cathode_next;
            row_valid_reg <= row_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        if (out_load) begin
            m_tdata_reg <= {cathode_reg, seg_out};
        end
    end

`include "assert_macros.svh"

    `SSF_ASSERT(a_cathode_onehot0, $onehot0(cathode_reg), "cathode not one-hot or zero")
    `SSF_ASSERT_ALWAYS(a_pready_high, pready, "apb port not ready")
    `SSF_ASSERT(a_split_in_flight, (state_reg == ST_SPLIT) |-> (split.busy || split.done), "split unit idle while awaited")
    `SSF_ASSERT(a_result_from_resp, $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_RESP), "result loaded outside response state")
    `SSF_ASSERT(a_split_only_show, split_start |-> (op_reg == ssf_pkg::OP_SHOW), "split started for a non-number request")

endmodule

FILE: sim/tb.sv
module tb;

    localparam int MAX_DIGITS       = 4;
    localparam int NUM_DISPLAYS     = 2;
    localparam int RANDOM_REQUESTS  = 1400;
    localparam int PHASES           = 8;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int REPORT_LIMIT     = 40;

    // active-low patterns of the decimal digits, digit 0 in the lowest byte
    localparam logic [79:0] DIGIT_SEGMENTS = {8'd9, 8'd1, 8'd31, 8'd65, 8'd73,
                                              8'd153, 8'd13, 8'd37, 8'd159, 8'd3};

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] value;
        logic        dot_flag;
        logic        display;
        logic [7:0]  raw_units;
        logic [7:0]  raw_tens;
        logic [7:0]  raw_hundreds;
        logic [7:0]  raw_thousands;
    } scan_request_t;

    // same bit order as m_tdata: segment_code low byte, digit_select high byte
    typedef struct packed {
        logic [7:0] digit_select;
        logic [7:0] segment_code;
    } lit_digit_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [55:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [15:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire  [31:0] prdata;
    wire         pready;

    // display settings and state as the block should hold them
    logic [2:0]  cfg_digits_first  = 3'd4;
    logic [2:0]  cfg_digits_second = 3'd4;
    logic [7:0]  cfg_blank         = 8'd255;
    logic [7:0]  cfg_minus         = 8'd253;
    logic [7:0]  cfg_error         = 8'd97;
    logic [7:0]  cfg_dot_mask      = 8'd254;
    logic [7:0]  shown_codes [0:7];
    logic [7:0]  lit_cathode       = 8'd0;

    scan_request_t pending_requests [$];
    lit_digit_t    expected_digits [$];
    scan_request_t offered_request;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    seven_segment_scan_formatter #(
        .MAX_DIGITS   (MAX_DIGITS),
        .NUM_DISPLAYS (NUM_DISPLAYS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // display model
    // ------------------------------------------------------------------

    function automatic int fitted_first();
        int n;
        n = int'(cfg_digits_first);
        if (n < 1) n = 1;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        return n;
    endfunction

    function automatic int fitted_second();
        int n;
        n = int'(cfg_digits_second);
        if (NUM_DISPLAYS < 2) n = 0;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        return n;
    endfunction

    // store slot of the lit digit, -1 when the cathode names no fitted digit
    function automatic int cathode_slot(logic [7:0] cat);
        int b;
        int slot;
        slot = -1;
        if (cat != 8'd0 && (cat & (cat - 8'd1)) == 8'd0) begin
            b = 0;
            while (!cat[b]) b++;
            if (b < 4) begin
                if (b < fitted_first()) slot = b;
            end else begin
                if (b - 4 < fitted_second()) slot = b;
            end
        end
        return slot;
    endfunction

    function automatic logic [7:0] next_scan_cathode();
        int         slot;
        logic [7:0] nxt;
        slot = cathode_slot(lit_cathode);
        nxt = 8'd1;  // restart at display zero units by default
        if (slot >= 0 && slot < 4) begin
            if (slot + 1 < fitted_first()) nxt = 8'd1 << (slot + 1);
            else if (fitted_second() > 0) nxt = 8'd16;
        end else if (slot >= 4) begin
            if (slot - 3 < fitted_second()) nxt = 8'd1 << (slot + 1);
        end
        return nxt;
    endfunction

    function automatic void format_number(logic [15:0] value, logic dot, logic disp);
        logic [7:0] code [0:4];
        logic       blank [0:4];
        int         d;
        int         i;
        int         v;
        int         mag;
        logic       neg;
        logic       placed;
        d = disp ? fitted_second() : fitted_first();
        if (d != 0) begin
            v = int'($signed(value));
            neg = v < 0;
            mag = neg ? -v : v;
            for (i = 0; i < 5; i++) begin
                code[i]  = cfg_blank;
                blank[i] = 1'b1;
            end
            for (i = 0; i < d; i++) begin
                code[i]  = DIGIT_SEGMENTS[8*(mag % 10) +: 8];
                blank[i] = 1'b0;
                mag = mag / 10;
            end
            // leading-zero blanking from the top, units always kept
            for (i = d - 1; i > 0; i--) begin
                if (blank[i+1] && code[i] == DIGIT_SEGMENTS[7:0]) begin
                    code[i]  = cfg_blank;
                    blank[i] = 1'b1;
                end
            end
            // overflow, or no room left for the sign
            if (mag > 0 || (neg && !blank[d-1])) begin
                code[d-1]  = cfg_error;
                blank[d-1] = 1'b0;
            end
            if (neg) begin
                placed = 1'b0;
                for (i = d - 1; i > 0; i--) begin
                    if (!placed && blank[i] && !blank[i-1]) begin
                        code[i]  = cfg_minus;
                        blank[i] = 1'b0;
                        placed   = 1'b1;
                    end
                end
            end
            if (dot) code[0] = code[0] & cfg_dot_mask;
            for (i = 0; i < 4; i++) shown_codes[int'(disp)*4 + i] = code[i];
        end
    endfunction

    // applies one request to the model and returns the digit it lights
    function automatic lit_digit_t apply_request(scan_request_t r);
        lit_digit_t res;
        int         base;
        int         slot;
        base = int'(r.display) * 4;
        case (r.operation)
            ssf_pkg::OP_SCAN: lit_cathode = next_scan_cathode();
            ssf_pkg::OP_SHOW: format_number(r.value, r.dot_flag, r.display);
            ssf_pkg::OP_RAW: begin
                shown_codes[base]     = r.raw_units;
                shown_codes[base + 1] = r.raw_tens;
                shown_codes[base + 2] = r.raw_hundreds;
                shown_codes[base + 3] = r.raw_thousands;
            end
            default: begin
                // clear writes even an absent display
                shown_codes[base]     = cfg_blank;
                shown_codes[base + 1] = cfg_blank;
                shown_codes[base + 2] = cfg_blank;
                shown_codes[base + 3] = cfg_blank;
            end
        endcase
        slot = cathode_slot(lit_cathode);
        res.segment_code = (slot >= 0) ? shown_codes[slot] : cfg_blank;
        res.digit_select = lit_cathode;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request generation
    // ------------------------------------------------------------------

    function automatic logic [55:0] pack_tdata(scan_request_t r);
        return {6'd0, r.raw_thousands, r.raw_hundreds, r.raw_tens, r.raw_units,
                r.display, r.dot_flag, r.value};
    endfunction

    function automatic scan_request_t make_request(logic [1:0] op, int value, logic dot,
                                                   logic disp, logic [31:0] raw);
        scan_request_t r;
        r.operation     = op;
        r.value         = value[15:0];
        r.dot_flag      = dot;
        r.display       = disp;
        r.raw_units     = raw[7:0];
        r.raw_tens      = raw[15:8];
        r.raw_hundreds  = raw[23:16];
        r.raw_thousands = raw[31:24];
        return r;
    endfunction

    // magnitudes weighted toward the blanking, sign and overflow boundaries
    function automatic logic [15:0] random_value();
        int          pick;
        int          mag;
        logic [15:0] v;
        pick = $urandom_range(99);
        if (pick < 30) mag = $urandom_range(120);
        else if (pick < 55) mag = $urandom_range(10999);
        else if (pick < 70) begin
            case ($urandom_range(7))
                0: mag = 9;
                1: mag = 10;
                2: mag = 99;
                3: mag = 100;
                4: mag = 999;
                5: mag = 1000;
                6: mag = 9999;
                default: mag = 10000;
            endcase
        end else mag = $urandom_range(65535);
        v = mag[15:0];
        if (pick < 70 && $urandom_range(1) == 1) v = -v;
        return v;
    endfunction

    function automatic scan_request_t random_request();
        scan_request_t r;
        int            pick;
        pick = $urandom_range(99);
        if (pick < 40) r.operation = ssf_pkg::OP_SCAN;
        else if (pick < 75) r.operation = ssf_pkg::OP_SHOW;
        else if (pick < 90) r.operation = ssf_pkg::OP_RAW;
        else r.operation = ssf_pkg::OP_CLEAR;
        r.value         = random_value();
        r.dot_flag      = 1'($urandom_range(1));
        r.display       = 1'($urandom_range(1));
        r.raw_units     = 8'($urandom_range(255));
        r.raw_tens      = 8'($urandom_range(255));
        r.raw_hundreds  = 8'($urandom_range(255));
        r.raw_thousands = 8'($urandom_range(255));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request driver: offers queued requests, predicts each accepted one
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : drive_requests
        scan_request_t nxt;
        if (s_tvalid && s_tready) expected_digits.push_back(apply_request(offered_request));
        // a request not yet taken stays on the bus unchanged
        if (!(s_tvalid && !s_tready)) begin
            if (aresetn && pending_requests.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_requests.pop_front();
                offered_request = nxt;
                s_tdata  <= pack_tdata(nxt);
                s_tuser  <= nxt.operation;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stalls
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : check_results
        lit_digit_t got;
        lit_digit_t want;
        if (m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_digits.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t unexpected result: expected none, actual seg %02h sel %02h",
                             $time, got.segment_code, got.digit_select);
                mismatch_count++;
            end else begin
                want = expected_digits.pop_front();
                if (got.segment_code !== want.segment_code) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t segment_code mismatch: expected %02h, actual %02h",
                                 $time, want.segment_code, got.segment_code);
                    mismatch_count++;
                end
                if (got.digit_select !== want.digit_select) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t digit_select mismatch: expected %02h, actual %02h",
                                 $time, want.digit_select, got.digit_select);
                    mismatch_count++;
                end
            end
        end
        // long hold-off, counted here so the sender keeps offering meanwhile
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_digits.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // configuration writes, only while the block is idle
    // ------------------------------------------------------------------

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);  // register written at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ssf_pkg::REG_DIGITS_FIRST:  cfg_digits_first  = data[2:0];
            ssf_pkg::REG_DIGITS_SECOND: cfg_digits_second = data[2:0];
            ssf_pkg::REG_BLANK_CODE:    cfg_blank         = data[7:0];
            ssf_pkg::REG_MINUS_CODE:    cfg_minus         = data[7:0];
            ssf_pkg::REG_ERROR_CODE:    cfg_error         = data[7:0];
            ssf_pkg::REG_DOT_MASK:      cfg_dot_mask      = data[7:0];
            default: ;
        endcase
    endtask

    task automatic configure_display(input logic [2:0] first, input logic [2:0] second,
                                     input logic [7:0] blank, input logic [7:0] minus,
                                     input logic [7:0] err, input logic [7:0] dmask);
        write_register(ssf_pkg::REG_DIGITS_FIRST, {29'd0, first});
        write_register(ssf_pkg::REG_DIGITS_SECOND, {29'd0, second});
        write_register(ssf_pkg::REG_BLANK_CODE, {24'd0, blank});
        write_register(ssf_pkg::REG_MINUS_CODE, {24'd0, minus});
        write_register(ssf_pkg::REG_ERROR_CODE, {24'd0, err});
        write_register(ssf_pkg::REG_DOT_MASK, {24'd0, dmask});
    endtask

    // sender pause: every request accepted and every result back
    // checked at the falling edge, once the driver's updates have settled
    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_digits.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin : run_test
        int phase;
        int i;
        for (i = 0; i < 8; i++) shown_codes[i] = 8'd0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed requests at reset settings: store reads zero until written
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        // nothing lit yet
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, 0, 1'b0, 1'b0, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SCAN, 0, 1'b0, 1'b0, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SCAN, 0, 1'b0, 1'b0, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, -1, 1'b1, 1'b0, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, 9999, 1'b0, 1'b0, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, -999, 1'b0, 1'b0, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, -1000, 1'b0, 1'b0, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, 10000, 1'b1, 1'b0, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, 32767, 1'b1, 1'b1, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, -32768, 1'b0, 1'b1, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, 1005, 1'b1, 1'b1, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, -7, 1'b0, 1'b1, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_RAW, 0, 1'b0, 1'b1,
                                                32'h0000_0000));
        pending_requests.push_back(make_request(ssf_pkg::OP_RAW, 0, 1'b0, 1'b0,
                                                32'hFFFF_FFFF));
        pending_requests.push_back(make_request(ssf_pkg::OP_RAW, 0, 1'b0, 1'b1,
                                                32'h5AA5_C33C));
        pending_requests.push_back(make_request(ssf_pkg::OP_CLEAR, 0, 1'b0, 1'b0, 32'h0));
        pending_requests.push_back(make_request(ssf_pkg::OP_SHOW, 40, 1'b0, 1'b0, 32'h0));
        // walk every fitted digit of both displays and wrap around
        for (i = 0; i < 8; i++)
            pending_requests.push_back(make_request(ssf_pkg::OP_SCAN, 0, 1'b0, 1'b0, 32'h0));
        wait_until_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            // digit counts cover zero, one, full and above-range encodings
            case (phase)
                0: configure_display(3'd4, 3'd4, 8'd255, 8'd253, 8'd97, 8'd254);
                1: configure_display(3'd1, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                2: configure_display(3'd0, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255);
                3: configure_display(3'd7, 3'd1, 8'($urandom_range(255)),
                                     8'($urandom_range(255)), 8'($urandom_range(255)),
                                     8'($urandom_range(255)));
                4: configure_display(3'd2, 3'd3, 8'($urandom_range(255)),
                                     8'($urandom_range(255)), 8'($urandom_range(255)),
                                     8'($urandom_range(255)));
                5: configure_display(3'd3, 3'd2, 8'($urandom_range(255)),
                                     8'($urandom_range(255)), 8'($urandom_range(255)),
                                     8'($urandom_range(255)));
                6: configure_display(3'd4, 3'd0, 8'($urandom_range(255)),
                                     8'($urandom_range(255)), 8'($urandom_range(255)),
                                     8'($urandom_range(255)));
                default: configure_display(3'd5, 3'd6, 8'($urandom_range(255)),
                                           8'($urandom_range(255)),
                                           8'($urandom_range(255)),
                                           8'($urandom_range(255)));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            for (i = 0; i < RANDOM_REQUESTS / PHASES; i++)
                pending_requests.push_back(random_request());
            // back up the result path while the sender keeps pushing requests
            if (phase == 2) hold_request = LONG_HOLD_CYCLES;
            wait_until_drained();
        end

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
